// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Port field widths
  localparam int MODE_W       = 2;
  localparam int VALUE_W      = 8;
  localparam int CELL_INDEX_W = 11;
  localparam int LINE_OUT_W   = 5;
  localparam int COL_OUT_W    = 7;
  localparam int CELL_W       = 16;

  // Request modes as they arrive on the input channel
  localparam logic [MODE_W-1:0] MODE_PRINT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ATTR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Request kinds after classification
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_CHAR    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RETURN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ATTR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd5;

  localparam logic [VALUE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [VALUE_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [VALUE_W-1:0] CHAR_BLANK = 8'h00;
  localparam logic [VALUE_W-1:0] ATTR_RESET = 8'h0F;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [VALUE_W-1:0]      value;
    logic [CELL_INDEX_W-1:0] cell_index;
  } tcw_cmd_t;

endpackage

// ===== rtl/tcw_front.sv =====
// Request decoder: accepts input requests and classifies them for the queue.
module tcw_front (
  input  logic                  in_valid,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_value,
  input  logic [10:0]           in_cell_index,
  output logic                  in_stall,
  input  logic                  q_full,
  input  logic                  busy,
  output logic                  push,
  output tcw_pkg::tcw_cmd_t     push_cmd
);
  import tcw_pkg::*;

  logic [KIND_W-1:0] kind;

  always_comb begin
    case (in_mode)
      MODE_PRINT: begin
        if (in_value == CH_NEWLINE) begin
          kind = KIND_NEWLINE;
        end else if (in_value == CH_RETURN) begin
          kind = KIND_RETURN;
        end else begin
          kind = KIND_CHAR;
        end
      end
      MODE_ATTR:  kind = KIND_ATTR;
      MODE_CLEAR: kind = KIND_CLEAR;
      MODE_READ:  kind = KIND_READ;
      default:    kind = KIND_READ;
    endcase
  end

  assign in_stall            = q_full || busy;
  assign push                = in_valid && !in_stall;
  assign push_cmd.kind       = kind;
  assign push_cmd.value      = in_value;
  assign push_cmd.cell_index = in_cell_index;

endmodule

// ===== rtl/tcw_queue.sv =====
// Short request queue between the decoder and the engine.
module tcw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcw_pkg::tcw_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tcw_pkg::tcw_cmd_t head_cmd
);
  import tcw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tcw_cmd_t         entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/tcw_engine.sv =====
// Console engine: cursor, attribute, circular screen store, sweeps and result register.
module tcw_engine #(
  parameter int LINE_COUNT   = 25,
  parameter int COLUMN_COUNT = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  tcw_pkg::tcw_cmd_t cmd,
  output logic              cmd_pop,
  output logic              busy,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [4:0]        out_cursor_line,
  output logic [6:0]        out_cursor_column,
  output logic              out_scrolled,
  output logic [7:0]        out_read_char,
  output logic [7:0]        out_read_attr
);
  import tcw_pkg::*;

  localparam int CELL_TOTAL = LINE_COUNT * COLUMN_COUNT;
  localparam int ADDR_W     = $clog2(CELL_TOTAL);
  localparam int SUM_W      = ADDR_W + 1;
  localparam int CNT_W      = $clog2(CELL_TOTAL + 1);
  localparam int LINE_W     = $clog2(LINE_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMN_COUNT + 1);
  localparam int IDX_W      = (CELL_INDEX_W > ADDR_W) ? CELL_INDEX_W : ADDR_W;
  localparam int EXT_W      = IDX_W + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_POST  = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  // Control state
  logic [1:0]         state_r, state_nxt;
  logic               init_r, init_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [VALUE_W-1:0] attr_r, attr_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [ADDR_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic [CNT_W-1:0]   sweep_left_r, sweep_left_nxt;
  logic               pend_wr_r, pend_wr_nxt;
  logic               scroll_r, scroll_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic [CELL_W-1:0]  pend_data_r, pend_data_nxt;
  logic               rd_hit_r, rd_hit_nxt;
  logic [CELL_W-1:0]  rd_data_r;
  logic [LINE_OUT_W-1:0] out_line_r;
  logic [COL_OUT_W-1:0]  out_col_r;
  logic                  out_scrolled_r;
  logic [VALUE_W-1:0]    out_char_r, out_attr_r;

  logic [CELL_W-1:0]  cell_mem [CELL_TOTAL];

  // Memory port controls
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [CELL_W-1:0]  wr_data;

  // Result load
  logic                  load_out, out_free;
  logic [LINE_OUT_W-1:0] res_line;
  logic [COL_OUT_W-1:0]  res_col;
  logic                  res_scrolled;
  logic [VALUE_W-1:0]    res_char, res_attr;

  // Print decode
  logic               line_pend, col_full;
  logic [ADDR_W-1:0]  row_plus, base_plus;
  logic               p_scroll, p_wr;
  logic [LINE_W-1:0]  p_line;
  logic [COL_W-1:0]   p_col;
  logic [ADDR_W-1:0]  p_row, p_wr_addr;

  // Read decode
  logic [EXT_W-1:0]   idx_ext, idx_sum;
  logic               idx_hit;
  logic [ADDR_W-1:0]  idx_phys;

  // Step a row address down one line in the circular store.
  function automatic logic [ADDR_W-1:0] next_row(input logic [ADDR_W-1:0] a);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(COLUMN_COUNT);
    if (s >= SUM_W'(CELL_TOTAL)) begin
      s = s - SUM_W'(CELL_TOTAL);
    end
    next_row = s[ADDR_W-1:0];
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign busy      = init_r;
  assign line_pend = (line_r == LINE_W'(LINE_COUNT));
  assign col_full  = (col_r == COL_W'(COLUMN_COUNT));
  assign row_plus  = next_row(row_r);
  assign base_plus = next_row(base_r);

  always_comb begin
    p_scroll = 1'b0;
    p_wr     = 1'b0;
    p_line   = line_r;
    p_col    = col_r;
    p_row    = row_r;
    if (line_pend) begin
      // Scroll left pending by an earlier step; cursor row stays physically put
      p_scroll = 1'b1;
      p_line   = LINE_W'(LINE_COUNT - 1);
      p_col    = '0;
    end
    if (cmd.kind == KIND_NEWLINE) begin
      p_line = p_line + 1'b1;
      p_col  = '0;
      p_row  = row_plus;
    end else if (cmd.kind == KIND_RETURN) begin
      p_col = '0;
    end else begin
      if (!line_pend && col_full) begin
        p_col = '0;
        p_row = row_plus;
        if (line_r == LINE_W'(LINE_COUNT - 1)) begin
          p_scroll = 1'b1;
        end else begin
          p_line = line_r + 1'b1;
        end
      end
      p_wr  = 1'b1;
    end
    p_wr_addr = p_row + ADDR_W'(p_col);
    if (p_wr) begin
      p_col = p_col + 1'b1;
    end
  end

  always_comb begin
    idx_ext  = EXT_W'(cmd.cell_index);
    idx_hit  = (idx_ext < EXT_W'(CELL_TOTAL));
    idx_sum  = idx_ext + EXT_W'(base_r);
    if (idx_sum >= EXT_W'(CELL_TOTAL)) begin
      idx_sum = idx_sum - EXT_W'(CELL_TOTAL);
    end
    idx_phys = idx_sum[ADDR_W-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    attr_nxt       = attr_r;
    base_nxt       = base_r;
    row_nxt        = row_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_left_nxt = sweep_left_r;
    pend_wr_nxt    = pend_wr_r;
    pend_addr_nxt  = pend_addr_r;
    pend_data_nxt  = pend_data_r;
    scroll_nxt     = scroll_r;
    rd_hit_nxt     = rd_hit_r;
    cmd_pop        = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = sweep_addr_r;
    wr_data        = {attr_r, CHAR_BLANK};
    rd_en          = 1'b0;
    rd_addr        = idx_phys;
    load_out       = 1'b0;
    res_line       = LINE_OUT_W'(line_r);
    res_col        = COL_OUT_W'(col_r);
    res_scrolled   = 1'b0;
    res_char       = '0;
    res_attr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            KIND_CHAR, KIND_NEWLINE, KIND_RETURN: begin
              line_nxt = p_line;
              col_nxt  = p_col;
              row_nxt  = p_row;
              if (p_scroll) begin
                // Drop the top line by moving the base, then blank the old top
                base_nxt       = base_plus;
                sweep_addr_nxt = base_r;
                sweep_left_nxt = CNT_W'(COLUMN_COUNT);
                pend_wr_nxt    = p_wr;
                pend_addr_nxt  = p_wr_addr;
                pend_data_nxt  = {attr_r, cmd.value};
                scroll_nxt     = 1'b1;
                state_nxt      = ST_SWEEP;
              end else begin
                wr_en    = p_wr;
                wr_addr  = p_wr_addr;
                wr_data  = {attr_r, cmd.value};
                load_out = 1'b1;
                res_line = LINE_OUT_W'(p_line);
                res_col  = COL_OUT_W'(p_col);
              end
            end
            KIND_ATTR: begin
              attr_nxt = cmd.value;
              load_out = 1'b1;
            end
            KIND_CLEAR: begin
              line_nxt       = '0;
              col_nxt        = '0;
              base_nxt       = '0;
              row_nxt        = '0;
              sweep_addr_nxt = '0;
              sweep_left_nxt = CNT_W'(CELL_TOTAL);
              pend_wr_nxt    = 1'b0;
              scroll_nxt     = 1'b0;
              state_nxt      = ST_SWEEP;
            end
            KIND_READ: begin
              rd_en      = idx_hit;
              rd_hit_nxt = idx_hit;
              state_nxt  = ST_READ;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        wr_en          = 1'b1;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        sweep_left_nxt = sweep_left_r - 1'b1;
        if (sweep_left_r == CNT_W'(1)) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (init_r) begin
          init_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          // Character held back until its line was blanked
          wr_en        = pend_wr_r;
          wr_addr      = pend_addr_r;
          wr_data      = pend_data_r;
          load_out     = 1'b1;
          res_scrolled = scroll_r;
          state_nxt    = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          load_out  = 1'b1;
          res_char  = rd_hit_r ? rd_data_r[VALUE_W-1:0] : '0;
          res_attr  = rd_hit_r ? rd_data_r[CELL_W-1:VALUE_W] : '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      init_r       <= 1'b1;
      line_r       <= '0;
      col_r        <= '0;
      attr_r       <= ATTR_RESET;
      base_r       <= '0;
      row_r        <= '0;
      sweep_addr_r <= '0;
      sweep_left_r <= CNT_W'(CELL_TOTAL);
      pend_wr_r    <= 1'b0;
      scroll_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      attr_r       <= attr_nxt;
      base_r       <= base_nxt;
      row_r        <= row_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_left_r <= sweep_left_nxt;
      pend_wr_r    <= pend_wr_nxt;
      scroll_r     <= scroll_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
    rd_hit_r    <= rd_hit_nxt;
    if (load_out) begin
      out_line_r     <= res_line;
      out_col_r      <= res_col;
      out_scrolled_r <= res_scrolled;
      out_char_r     <= res_char;
      out_attr_r     <= res_attr;
    end
  end

  // Screen store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cell_mem[rd_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_line   = out_line_r;
  assign out_cursor_column = out_col_r;
  assign out_scrolled      = out_scrolled_r;
  assign out_read_char     = out_char_r;
  assign out_read_attr     = out_attr_r;

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: decoder, request queue and engine.
//
//  Channel   Direction  Handshake          Payload
//  in_       request    in_valid/in_stall  in_mode, in_value, in_cell_index
//  out_      result     out_valid/out_stall out_cursor_line, out_cursor_column,
//                                          out_scrolled, out_read_char, out_read_attr
//
// Print, newline, return and set-attribute without a scroll complete from the idle state; a
// cell read passes through a read state (registered read port of the cell store).
// A scroll blanks COLUMN_COUNT cells and a clear LINE_COUNT * COLUMN_COUNT cells in the sweep
// state, the single write port sweeping one cell per cycle, and both finish in the post state.
// After reset the store is swept to blank cells with in_stall held high.
// A two-entry queue lets requests arrive while the engine sweeps or out_stall holds a result.
module text_console_writer #(
  parameter int LINE_COUNT   = 25,
  parameter int COLUMN_COUNT = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_value,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_cursor_line,
  output logic [6:0]  out_cursor_column,
  output logic        out_scrolled,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attr
);
  import tcw_pkg::*;

  logic     push, q_full, busy;
  logic     head_valid, pop;
  tcw_cmd_t push_cmd, head_cmd;

  // Classify each request; stall while the queue is full or the reset sweep runs
  tcw_front u_front (
    .in_valid      (in_valid),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .in_cell_index (in_cell_index),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Screen is kept as a circular line buffer: a scroll moves the base line
  // and blanks one line instead of copying the whole store.
  tcw_engine #(
    .LINE_COUNT   (LINE_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (head_valid),
    .cmd               (head_cmd),
    .cmd_pop           (pop),
    .busy              (busy),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_cursor_line   (out_cursor_line),
    .out_cursor_column (out_cursor_column),
    .out_scrolled      (out_scrolled),
    .out_read_char     (out_read_char),
    .out_read_attr     (out_read_attr)
  );

endmodule
